>>> sv/hsl_hr_pkg.sv
package hsl_hr_pkg;

  // Input pixel request: one 8-bit RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  // Result request: the hue-rotated pixel.
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // Piece of the hue-to-channel curve that a channel falls in.
  typedef enum logic [2:0] {
    SEG_RAMP = 3'b001,
    SEG_HIGH = 3'b010,
    SEG_LOW  = 3'b100
  } seg_t;

  // Hue offset of each channel in thirds of a turn: red, green, blue.
  localparam int NUM_CH = 3;
  localparam logic [1:0] CH_OFS [NUM_CH] = '{2'd1, 2'd0, 2'd2};

endpackage

>>> sv/hsl_hue_rotate_pixel.sv
// Hue rotation of an 8-bit RGB pixel stream. Each pixel is taken to hue, saturation and
// lightness in unsigned fixed point with FRACTION_BITS fraction bits, its hue is advanced by
// the cfg_wr_data value (units of 1/65536 turn, written when cfg_wr_en is high, reset 0),
// and it is turned back into RGB with each channel truncated and clamped to 0..255. Grey
// pixels pass unchanged. The block is an eight-stage pipeline: it accepts one pixel every
// clock. The whole pipeline advances together, so it stops only while a finished result is
// held at the output and out_ready is low. Write the shift only while no pixels are in
// flight.
module hsl_hue_rotate_pixel #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsl_hr_pkg::pix_in_t  in_pix,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsl_hr_pkg::pix_out_t out_pix
);
  import hsl_hr_pkg::*;

  localparam int FB = FRACTION_BITS;
  localparam int KR = FB + 12;
  localparam int RW = KR + 1;
  localparam int XW = FB + 12;
  localparam int K6 = FB + 4;
  localparam int NSTG = 8;
  localparam longint RecipNum = longint'(1) << KR;
  localparam longint Recip6Num = longint'(1) << K6;
  localparam logic [RW-1:0] RECIP510 = RW'(RecipNum / 510);
  localparam logic [K6-1:0] RECIP6 = K6'(Recip6Num / 6);
  localparam logic [FB+2:0] ONE = (FB+3)'(1) << FB;

  // Reciprocal table: floor(2^KR / n) for divisors 1..255.
  logic [RW-1:0] recip_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam int Div = (gi == 0) ? 1 : gi;
    localparam logic [RW-1:0] RecipVal = RW'(RecipNum / Div);
    assign recip_tab[gi] = RecipVal;
  end

  logic [15:0]     hue_shift_r;
  logic [NSTG-1:0] vld_r;
  logic            en;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_shift_r <= '0;
    end else if (cfg_wr_en) begin
      hue_shift_r <= cfg_wr_data;
    end
  end

  // The pipeline moves as one whenever the output slot is free or being emptied.
  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Stage 1: max, min, chroma, lightness sum and hue numerator.
  logic [7:0]  mx, mn, dd, den;
  logic [8:0]  sum;
  logic [10:0] num;
  logic [7:0]  mx1_r, d1_r, den1_r;
  logic [8:0]  sum1_r;
  logic [10:0] num1_r;
  logic        grey1_r;

  always_comb begin
    mx = in_pix.red;
    mn = in_pix.red;
    if (in_pix.green > mx) mx = in_pix.green;
    if (in_pix.blue > mx) mx = in_pix.blue;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue < mn) mn = in_pix.blue;
    dd  = mx - mn;
    sum = 9'(mx) + 9'(mn);
    den = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
    if (den == 8'd0) den = 8'd1;
    if (mx == in_pix.red) begin
      if (in_pix.green >= in_pix.blue) begin
        num = 11'(in_pix.green) - 11'(in_pix.blue);
      end else begin
        num = 11'(6) * 11'(dd) - (11'(in_pix.blue) - 11'(in_pix.green));
      end
    end else if (mx == in_pix.green) begin
      num = 11'(2) * 11'(dd) + 11'(in_pix.blue) - 11'(in_pix.red);
    end else begin
      num = 11'(4) * 11'(dd) + 11'(in_pix.red) - 11'(in_pix.green);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r   <= mx;
      d1_r    <= dd;
      den1_r  <= den;
      sum1_r  <= sum;
      num1_r  <= num;
      grey1_r <= (dd == 8'd0);
    end
  end

  // Stage 2: quotient estimates by reciprocal multiplication, low by at most one.
  logic [FB+20:0] prod_s;
  logic [FB+23:0] prod_h;
  logic [FB+21:0] prod_l;
  logic [FB:0]    q0s2_r;
  logic [FB+2:0]  q0h2_r;
  logic [FB-1:0]  q0l2_r;
  logic [7:0]     mx2_r, d2_r, den2_r;
  logic [8:0]     sum2_r;
  logic [10:0]    num2_r;
  logic           grey2_r;

  assign prod_s = (FB+21)'(d1_r) * (FB+21)'(recip_tab[den1_r]);
  assign prod_h = (FB+24)'(num1_r) * (FB+24)'(recip_tab[d1_r]);
  assign prod_l = (FB+22)'(sum1_r) * (FB+22)'(RECIP510);

  always_ff @(posedge clk) begin
    if (en) begin
      q0s2_r  <= prod_s[FB+12:12];
      q0h2_r  <= prod_h[FB+14:12];
      q0l2_r  <= prod_l[FB+11:12];
      mx2_r   <= mx1_r;
      d2_r    <= d1_r;
      den2_r  <= den1_r;
      sum2_r  <= sum1_r;
      num2_r  <= num1_r;
      grey2_r <= grey1_r;
    end
  end

  // Stage 3: remainder check corrects each quotient to the exact floor.
  logic [XW-1:0] rem_s, rem_h, rem_l;
  logic [FB:0]   s3_r;
  logic [FB+2:0] hd3_r;
  logic [FB-1:0] l3_r;
  logic [7:0]    mx3_r;
  logic          lowsum3_r, grey3_r;

  assign rem_s = (XW'(d2_r) << FB) - XW'((FB+9)'(q0s2_r) * (FB+9)'(den2_r));
  assign rem_h = (XW'(num2_r) << FB) - XW'((FB+11)'(q0h2_r) * (FB+11)'(d2_r));
  assign rem_l = (XW'(sum2_r) << FB) - XW'((FB+9)'(q0l2_r) * (FB+9)'(9'd510));

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r      <= q0s2_r + (FB+1)'(rem_s >= XW'(den2_r));
      hd3_r     <= q0h2_r + (FB+3)'(rem_h >= XW'(d2_r));
      l3_r      <= q0l2_r + FB'(rem_l >= XW'(9'd510));
      lowsum3_r <= (sum2_r < 9'd255);
      mx3_r     <= mx2_r;
      grey3_r   <= grey2_r;
    end
  end

  // Stage 4: hue divided by six, and the product for the upper lightness level.
  logic [FB+K6+2:0] prod6;
  logic [FB+1:0]    mb;
  logic [FB-1:0]    q064_r, l4_r;
  logic [FB+2:0]    hd4_r;
  logic [2*FB+1:0]  prodq4_r;
  logic [FB:0]      s4_r;
  logic [7:0]       mx4_r;
  logic             lowsum4_r, grey4_r;

  assign prod6 = (FB+K6+3)'(hd3_r) * (FB+K6+3)'(RECIP6);
  assign mb    = lowsum3_r ? ((FB+2)'(ONE) + (FB+2)'(s3_r)) : (FB+2)'(s3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q064_r    <= prod6[K6+FB-1:K6];
      hd4_r     <= hd3_r;
      prodq4_r  <= (2*FB+2)'(l3_r) * (2*FB+2)'(mb);
      l4_r      <= l3_r;
      s4_r      <= s3_r;
      lowsum4_r <= lowsum3_r;
      mx4_r     <= mx3_r;
      grey4_r   <= grey3_r;
    end
  end

  // Stage 5: exact hue, shifted hue, and the two lightness levels.
  logic [FB+2:0]        rem6;
  logic [FB-1:0]        hue, sh;
  logic [FB+15:0]       sh_wide;
  logic [FB+1:0]        qv;
  logic [FB+1:0]        q5_r;
  logic signed [FB+2:0] p5_r;
  logic [FB-1:0]        hs5_r;
  logic [7:0]           mx5_r;
  logic                 grey5_r;

  always_comb begin
    rem6    = hd4_r - (FB+3)'(q064_r) * (FB+3)'(6);
    hue     = q064_r + FB'(rem6 >= (FB+3)'(6));
    sh_wide = {hue_shift_r, FB'(0)} >> 16;
    sh      = sh_wide[FB-1:0];
    if (lowsum4_r) begin
      qv = prodq4_r[2*FB+1:FB];
    end else begin
      qv = (FB+2)'(l4_r) + (FB+2)'(s4_r) - prodq4_r[2*FB+1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q5_r    <= qv;
      p5_r    <= $signed((FB+3)'({l4_r, 1'b0})) - $signed((FB+3)'(qv));
      hs5_r   <= hue + sh;
      mx5_r   <= mx4_r;
      grey5_r <= grey4_r;
    end
  end

  // Stage 6: per-channel hue position, curve piece and ramp fraction.
  logic [FB+1:0]        h3;
  logic [FB+2:0]        tt [NUM_CH];
  seg_t                 seg [NUM_CH];
  logic [FB:0]          ff [NUM_CH];
  seg_t                 seg6_r [NUM_CH];
  logic [FB:0]          f6_r [NUM_CH];
  logic [FB+1:0]        q6_r;
  logic signed [FB+2:0] p6_r;
  logic [7:0]           mx6_r;
  logic                 grey6_r;

  always_comb begin
    h3 = (FB+2)'(hs5_r) * (FB+2)'(3);
    for (int c = 0; c < NUM_CH; c++) begin
      tt[c] = (FB+3)'(h3) + ((FB+3)'(CH_OFS[c]) << FB);
      if (tt[c] >= (FB+3)'(3) * ONE) tt[c] = tt[c] - (FB+3)'(3) * ONE;
      if ((tt[c] << 1) < ONE) begin
        seg[c] = SEG_RAMP;
        ff[c]  = (FB+1)'(tt[c] << 1);
      end else if ((tt[c] << 1) < (FB+3)'(3) * ONE) begin
        seg[c] = SEG_HIGH;
        ff[c]  = '0;
      end else if (tt[c] < (ONE << 1)) begin
        seg[c] = SEG_RAMP;
        ff[c]  = (FB+1)'(((ONE << 1) - tt[c]) << 1);
      end else begin
        seg[c] = SEG_LOW;
        ff[c]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg6_r  <= seg;
      f6_r    <= ff;
      q6_r    <= q5_r;
      p6_r    <= p5_r;
      mx6_r   <= mx5_r;
      grey6_r <= grey5_r;
    end
  end

  // Stage 7: channel level on the curve.
  logic signed [FB+3:0] dsum;
  logic [FB+2:0]        diff;
  logic [2*FB+3:0]      prodc [NUM_CH];
  logic signed [FB+4:0] cv [NUM_CH];
  logic signed [FB+4:0] c7_r [NUM_CH];
  logic [7:0]           mx7_r;
  logic                 grey7_r;

  always_comb begin
    dsum = $signed((FB+4)'(q6_r)) - $signed({p6_r[FB+2], p6_r});
    diff = dsum[FB+2:0];
    for (int c = 0; c < NUM_CH; c++) begin
      prodc[c] = (2*FB+4)'(diff) * (2*FB+4)'(f6_r[c]);
      case (seg6_r[c])
        SEG_RAMP: cv[c] = $signed({{2{p6_r[FB+2]}}, p6_r})
                          + $signed({1'b0, prodc[c][2*FB+3:FB]});
        SEG_HIGH: cv[c] = $signed((FB+5)'(q6_r));
        SEG_LOW:  cv[c] = $signed({{2{p6_r[FB+2]}}, p6_r});
        default:  cv[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c7_r    <= cv;
      mx7_r   <= mx6_r;
      grey7_r <= grey6_r;
    end
  end

  // Stage 8: scale by 255, truncate and clamp; grey pixels pass as they came.
  logic [FB+11:0] scaled [NUM_CH];
  logic [7:0]     chv [NUM_CH];
  pix_out_t       out_pix_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      scaled[c] = ((FB+12)'(c7_r[c][FB+3:0]) << 8) - (FB+12)'(c7_r[c][FB+3:0]);
      if (grey7_r) begin
        chv[c] = mx7_r;
      end else if (c7_r[c][FB+4] || c7_r[c] == '0) begin
        chv[c] = 8'd0;
      end else if (scaled[c][FB+11:FB] > 12'd255) begin
        chv[c] = 8'd255;
      end else begin
        chv[c] = scaled[c][FB+7:FB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r.red_out   <= chv[0];
      out_pix_r.green_out <= chv[1];
      out_pix_r.blue_out  <= chv[2];
    end
  end

  assign out_pix = out_pix_r;

  // A held result must block new pixels.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A ramp fraction never exceeds one.
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] && seg6_r[0] == SEG_RAMP |-> f6_r[0] <= (FB+1)'(ONE))
    else $error("ramp fraction above one");

endmodule

>>> tb/sv/tb_hsl_hue_rotate_pixel.sv
module tb_hsl_hue_rotate_pixel;
  import hsl_hr_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam int LATENCY = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 1150;
  localparam int NUM_DIRECTED = 20;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  pix_in_t in_pix;
  logic out_valid;
  logic out_ready;
  pix_out_t out_pix;

  // Directed row: pixel, and a known result where one can be read off directly.
  typedef struct {
    pix_in_t pix;
    bit has_known;
    pix_out_t known;
  } directed_row_t;

  pix_out_t rotated_q[$];
  logic [15:0] shift_reg;
  int errors;
  int n_sent;
  int n_recv;
  int idle_cycles;
  bit long_hold;
  bit tx_done;
  directed_row_t dir_tab[NUM_DIRECTED];

  hsl_hue_rotate_pixel u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pix(in_pix),
    .out_valid(out_valid), .out_ready(out_ready), .out_pix(out_pix)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Value of one channel on the piecewise hue curve.
  function automatic longint curve_value(longint p, longint q, longint t);
    if (2 * t < ONE) return p + ((q - p) * 2 * t) / ONE;
    if (2 * t < 3 * ONE) return q;
    if (t < 2 * ONE) return p + ((q - p) * 2 * (2 * ONE - t)) / ONE;
    return p;
  endfunction

  function automatic logic [7:0] scale_channel(longint c);
    longint v;
    if (c <= 0) return 8'd0;
    v = (c * 255) >>> FB;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Expected rotated pixel for the current hue shift.
  function automatic pix_out_t rotate_hue(pix_in_t px, logic [15:0] shift);
    longint r, g, b, mx, mn, d, sum, num, lig, sat, hue, denom, q, p, h3;
    pix_out_t res;
    r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) begin
      res.red_out = mx[7:0]; res.green_out = mx[7:0]; res.blue_out = mx[7:0];
      return res;
    end
    sum = mx + mn;
    lig = (sum * ONE) / 510;
    denom = (sum > 255) ? (510 - sum) : sum;
    if (denom == 0) denom = 1;
    sat = (d * ONE) / denom;
    if (mx == r) num = (g >= b) ? (g - b) : (6 * d - (b - g));
    else if (mx == g) num = 2 * d + b - r;
    else num = 4 * d + r - g;
    hue = (num * ONE) / (6 * d);
    hue = (hue + ((longint'(shift) << FB) >>> 16)) % ONE;
    if (sum < 255) q = (lig * (ONE + sat)) >>> FB;
    else q = lig + sat - ((lig * sat) >>> FB);
    p = 2 * lig - q;
    h3 = 3 * hue;
    res.red_out = scale_channel(curve_value(p, q, (h3 + ONE) % (3 * ONE)));
    res.green_out = scale_channel(curve_value(p, q, h3));
    res.blue_out = scale_channel(curve_value(p, q, (h3 + 2 * ONE) % (3 * ONE)));
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    int mode;
    mode = $urandom_range(0, 9);
    px = pix_in_t'(24'($urandom));
    if (mode == 0) begin
      px.green = px.red; px.blue = px.red;
    end else if (mode == 1) begin
      px.red = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    end
    return px;
  endfunction

  // Offer one pixel request and wait until it is accepted; valid drops only for a gap.
  task automatic send_pixel(pix_in_t px);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pix <= px;
    rotated_q.push_back(rotate_hue(px, shift_reg));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_shift(logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shift_reg = value;
  endtask

  function automatic directed_row_t row(int r, int g, int b, bit known);
    directed_row_t e;
    e.pix.red = 8'(r); e.pix.green = 8'(g); e.pix.blue = 8'(b);
    e.has_known = known;
    e.known.red_out = 8'(r); e.known.green_out = 8'(g); e.known.blue_out = 8'(b);
    return e;
  endfunction

  // Stimulus: directed table, then random phases under several shift settings.
  initial begin
    logic [15:0] shifts[6];
    pix_out_t exp_pix;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_pix = '0;
    shift_reg = '0;
    errors = 0;
    n_sent = 0;
    tx_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Grey and unchanged-at-zero-shift rows are known outright.
    dir_tab[0] = row(0, 0, 0, 1);
    dir_tab[1] = row(255, 255, 255, 1);
    dir_tab[2] = row(128, 128, 128, 1);
    dir_tab[3] = row(255, 0, 0, 1);
    dir_tab[4] = row(0, 255, 0, 1);
    dir_tab[5] = row(0, 0, 255, 1);
    dir_tab[6] = row(255, 255, 0, 0);
    dir_tab[7] = row(0, 255, 255, 0);
    dir_tab[8] = row(255, 0, 255, 0);
    dir_tab[9] = row(1, 0, 0, 0);
    dir_tab[10] = row(255, 254, 254, 0);
    dir_tab[11] = row(128, 127, 127, 0);
    dir_tab[12] = row(200, 50, 100, 0);
    dir_tab[13] = row(10, 200, 30, 0);
    dir_tab[14] = row(30, 60, 250, 0);
    dir_tab[15] = row(170, 85, 85, 0);
    dir_tab[16] = row(0, 128, 127, 0);
    dir_tab[17] = row(254, 1, 128, 0);
    dir_tab[18] = row(85, 170, 0, 0);
    dir_tab[19] = row(127, 0, 128, 0);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_known) begin
        exp_pix = rotate_hue(dir_tab[i].pix, shift_reg);
        if (exp_pix != dir_tab[i].known) begin
          $error("directed row %0d: predictor %h, table %h", i, exp_pix, dir_tab[i].known);
          errors++;
        end
      end
      send_pixel(dir_tab[i].pix);
    end
    wait_drained();

    shifts = '{16'hFFFF, 16'h0001, 16'h5555, 16'h8000, 16'hAAAB, 16'h0000};
    foreach (shifts[k]) begin
      write_shift(k == 5 ? 16'($urandom) : shifts[k]);
      for (int i = 0; i < NUM_RANDOM / 6; i++) begin
        send_pixel(random_pixel());
        if (i == 40 && k == 1) wait_drained();
      end
      wait_drained();
    end
    tx_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off while the sender keeps going.
  initial begin
    int stall;
    out_ready = 1'b0;
    long_hold = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold && n_sent > 300) begin
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      stall = gap_len();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pix_out_t exp_pix;
    if (rst_n && out_valid && out_ready) begin
      n_recv++;
      if (rotated_q.size() == 0) begin
        $error("unexpected result %h", out_pix);
        errors++;
      end else begin
        exp_pix = rotated_q.pop_front();
        if (out_pix.red_out !== exp_pix.red_out) begin
          $error("red_out: expected %0d, actual %0d", exp_pix.red_out, out_pix.red_out);
          errors++;
        end
        if (out_pix.green_out !== exp_pix.green_out) begin
          $error("green_out: expected %0d, actual %0d", exp_pix.green_out, out_pix.green_out);
          errors++;
        end
        if (out_pix.blue_out !== exp_pix.blue_out) begin
          $error("blue_out: expected %0d, actual %0d", exp_pix.blue_out, out_pix.blue_out);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request; also ends the run.
  initial begin
    n_recv = 0;
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (tx_done) begin
        if (rotated_q.size() != 0) begin
          $error("%0d expected results never arrived", rotated_q.size());
          errors++;
        end
        $display("Covered %0d pixels and %0d results over six hue shift settings.",
                 n_sent, n_recv);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", rotated_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
